FILE: design/btw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btw_pkg
// Shared types and constants for the BER TLV stream walker.
// ----------------------------------------------------------------------------
package btw_pkg;

  localparam int MAX_DEPTH_DEF   = 16;
  localparam int LEN_BYTES_DEF   = 4;
  localparam int OFFSET_BITS_DEF = 24;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERRUN  = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_DEEP     = 3'd3;
  localparam logic [2:0] ST_UNSUP    = 3'd4;

  localparam logic [7:0] ID_CLASS_M  = 8'hc0;
  localparam logic [7:0] ID_CONS_M   = 8'h20;
  localparam logic [7:0] ID_TAG_M    = 8'h1f;
  localparam logic [7:0] LEN_LONG_M  = 8'h80;
  localparam logic [7:0] LOW7_M      = 8'h7f;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  id_class;
    logic        constructed;
    logic [27:0] tag_number;
    logic [4:0]  level;
    logic [23:0] object_offset;
    logic [3:0]  hdr_len;
    logic [31:0] body_len;
    logic        indefinite;
    logic [2:0]  status;
    logic        last_result;
  } out_beat_t;

  // up to two results per input beat
  typedef struct packed {
    logic      two;
    out_beat_t r0;
    out_beat_t r1;
  } res_pair_t;

endpackage

FILE: design/btw_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btw_walker
// Front end: consumes one byte per beat, tracks header state and nesting
// stack, and produces up to two result records for that byte.
// ----------------------------------------------------------------------------
module btw_walker #(
  parameter int MAX_DEPTH   = btw_pkg::MAX_DEPTH_DEF,
  parameter int LEN_BYTES   = btw_pkg::LEN_BYTES_DEF,
  parameter int OFFSET_BITS = btw_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                allow_indef,
  input  logic                step,
  input  btw_pkg::in_beat_t   beat,
  output logic                res_valid,
  output btw_pkg::res_pair_t  res
);
  import btw_pkg::*;

  localparam int SPW = $clog2(MAX_DEPTH + 1);
  localparam int SIW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int OW  = OFFSET_BITS + 1;
  localparam int SW  = ((OW > 32) ? OW : 32) + 1;
  localparam logic [OW-1:0] OFF_LIM = {1'b1, {OFFSET_BITS{1'b0}}};

  typedef enum logic [5:0] {
    PH_ID   = 6'b000001,
    PH_TAG  = 6'b000010,
    PH_LEN0 = 6'b000100,
    PH_LENN = 6'b001000,
    PH_BODY = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [27:0]       tag_r, tag_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [3:0]        lleft_r, lleft_nxt;
  logic [3:0]        hcnt_r, hcnt_nxt;
  logic [OW-1:0]     off_r, off_nxt;
  logic [OW-1:0]     soff_r, soff_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  logic [2:0]        err_r, err_nxt;
  logic [OW-1:0]     end_stk_r [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] indef_r, bnd_r, indef_nxt, bnd_nxt;
  logic [MAX_DEPTH-1:0] hit;
  logic              push;
  logic [OW-1:0]     push_val;
  logic              res_valid_r;
  res_pair_t         res_r, res_nxt;

  // header completion terms
  logic        fin, fin_indef;
  logic [31:0] fin_len;
  logic [OW-1:0] pos, hdr_end, obj_end, lim;
  logic [SW-1:0] end_sum;
  logic        bounded, cons, eoc;
  logic [2:0]  fst;
  logic [SIW-1:0] top;
  logic [7:0]  b;
  out_beat_t   obj, sts;
  logic        have_obj;
  logic [SPW-1:0] pops;
  logic        ovr;

  assign b    = beat.data_byte;
  assign pos  = off_r;
  assign cons = id_r[5];
  assign top  = SIW'(sp_r - SPW'(1));
  assign hdr_end = pos + OW'(1);

  always_comb begin
    fin = 1'b0; fin_indef = 1'b0; fin_len = 32'd0;
    if (phase_r == PH_LEN0 && !b[7]) begin
      fin = 1'b1; fin_len = {24'd0, b};
    end else if (phase_r == PH_LEN0 && b == LEN_LONG_M) begin
      fin = 1'b1; fin_indef = 1'b1;
    end else if (phase_r == PH_LENN && len_r[31:24] == 8'd0 && lleft_r <= 4'd1) begin
      fin = 1'b1; fin_len = {len_r[23:0], b};
    end
  end

  always_comb begin
    lim = OFF_LIM; bounded = 1'b0; eoc = 1'b0;
    if (sp_r != '0) begin
      lim = end_stk_r[top];
      bounded = bnd_r[top];
      eoc = !fin_indef && fin_len == 32'd0 && id_r == 8'd0 && indef_r[top];
    end
  end

  assign end_sum = SW'(hdr_end) + SW'(fin_len);
  assign obj_end = fin_indef ? hdr_end : OW'(end_sum);
  assign ovr     = end_sum > SW'(lim);

  always_comb begin
    fst = ST_OK;
    if (fin_indef && (!allow_indef || !cons)) fst = ST_UNSUP;
    else if (ovr) fst = bounded ? ST_OVERRUN : ST_UNSUP;
    else if (cons && sp_r >= SPW'(MAX_DEPTH)) fst = ST_DEEP;
  end

  always_comb begin
    phase_nxt = phase_r; tag_nxt = tag_r; len_nxt = len_r; lleft_nxt = lleft_r;
    hcnt_nxt = hcnt_r; off_nxt = off_r; soff_nxt = soff_r; id_nxt = id_r;
    sp_nxt = sp_r; err_nxt = err_r; indef_nxt = indef_r; bnd_nxt = bnd_r;
    push = 1'b0; push_val = lim; have_obj = 1'b0; pops = '0; hit = '0;
    obj = '0;
    obj.id_class = id_r[7:6];
    obj.constructed = id_r[5];
    obj.tag_number = tag_r;
    obj.level = 5'(sp_r);
    obj.object_offset = 24'(soff_r);
    obj.hdr_len = hcnt_r + 4'd1;
    obj.body_len = fin_indef ? 32'd0 : fin_len;
    obj.indefinite = fin_indef;
    obj.status = fst;
    if (err_r == ST_OK) begin
      if (off_r >= OFF_LIM) begin
        err_nxt = ST_UNSUP; phase_nxt = PH_ERR;
      end else begin
        off_nxt = off_r + OW'(1);
        unique case (phase_r)
          PH_ID: begin
            soff_nxt = pos; id_nxt = b; hcnt_nxt = 4'd1;
            if ((b & ID_TAG_M) == ID_TAG_M) begin
              tag_nxt = '0; phase_nxt = PH_TAG;
            end else begin
              tag_nxt = {23'd0, b[4:0]}; phase_nxt = PH_LEN0;
            end
          end
          PH_TAG: begin
            if (hcnt_r >= 4'd5) begin
              err_nxt = ST_UNSUP; phase_nxt = PH_ERR;
            end else begin
              hcnt_nxt = hcnt_r + 4'd1;
              tag_nxt = {tag_r[20:0], b[6:0]};
              if (!b[7]) phase_nxt = PH_LEN0;
            end
          end
          PH_LEN0, PH_LENN: begin
            hcnt_nxt = hcnt_r + 4'd1;
            if (phase_r == PH_LENN && len_r[31:24] != 8'd0) begin
              err_nxt = ST_UNSUP; phase_nxt = PH_ERR;
            end else if (phase_r == PH_LEN0 && !fin &&
                         (b == 8'hff || (b & LOW7_M) > 8'(LEN_BYTES))) begin
              err_nxt = ST_UNSUP; phase_nxt = PH_ERR;
            end else if (!fin && phase_r == PH_LEN0) begin
              len_nxt = '0; lleft_nxt = b[3:0]; phase_nxt = PH_LENN;
            end else if (!fin) begin
              len_nxt = {len_r[23:0], b}; lleft_nxt = lleft_r - 4'd1;
            end else begin
              have_obj = 1'b1;
              if (fst != ST_OK) begin
                err_nxt = fst; phase_nxt = PH_ERR;
              end else begin
                phase_nxt = PH_ID;
                if (eoc) begin
                  sp_nxt = sp_r - SPW'(1);
                end else if (cons) begin
                  push = 1'b1;
                  push_val = fin_indef ? lim : obj_end;
                  indef_nxt[SIW'(sp_r)] = fin_indef;
                  bnd_nxt[SIW'(sp_r)] = fin_indef ? bounded : 1'b1;
                  sp_nxt = sp_r + SPW'(1);
                end else if (fin_len != 32'd0) begin
                  len_nxt = fin_len; phase_nxt = PH_BODY;
                end
              end
            end
          end
          PH_BODY: begin
            if (len_r <= 32'd1) phase_nxt = PH_ID;
            len_nxt = (len_r != 32'd0) ? len_r - 32'd1 : 32'd0;
          end
          default: ;
        endcase
        // close definite containers ending here (contiguous from the top)
        if (phase_nxt == PH_ID && err_nxt == ST_OK) begin
          for (int i = 0; i < MAX_DEPTH; i++)
            hit[i] = !indef_nxt[i] &&
                     (((push && SPW'(i) == sp_r) ? push_val : end_stk_r[i]) == hdr_end);
          for (int i = 0; i < MAX_DEPTH; i++)
            if (SPW'(i) < sp_nxt && hit[i]) begin
              pops = SPW'(i);
              for (int j = i; j < MAX_DEPTH; j++)
                if (SPW'(j) < sp_nxt && !hit[j]) pops = sp_nxt;
              if (pops != sp_nxt) begin
                sp_nxt = SPW'(i);
                break;
              end
            end
        end
      end
    end
    sts = '0;
    sts.kind = 1'b1;
    sts.level = 5'(sp_nxt);
    sts.object_offset = 24'(off_nxt);
    sts.status = (err_nxt == ST_OK && (phase_nxt != PH_ID || sp_nxt != '0)) ?
                 ST_TRUNC : err_nxt;
    sts.last_result = 1'b1;
    obj.last_result = !beat.last_byte;
    res_nxt.two = have_obj && beat.last_byte;
    res_nxt.r0 = have_obj ? obj : sts;
    res_nxt.r1 = sts;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID; tag_r <= '0; len_r <= '0; lleft_r <= '0; hcnt_r <= '0;
      off_r <= '0; soff_r <= '0; id_r <= '0; sp_r <= '0; err_r <= ST_OK;
      indef_r <= '0; bnd_r <= '0; res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= step && (have_obj || beat.last_byte);
      if (step) begin
        if (beat.last_byte) begin
          phase_r <= PH_ID; tag_r <= '0; len_r <= '0; lleft_r <= '0; hcnt_r <= '0;
          off_r <= '0; soff_r <= '0; id_r <= '0; sp_r <= '0; err_r <= ST_OK;
          indef_r <= '0; bnd_r <= '0;
        end else begin
          phase_r <= phase_nxt; tag_r <= tag_nxt; len_r <= len_nxt;
          lleft_r <= lleft_nxt; hcnt_r <= hcnt_nxt; off_r <= off_nxt;
          soff_r <= soff_nxt; id_r <= id_nxt; sp_r <= sp_nxt; err_r <= err_nxt;
          indef_r <= indef_nxt; bnd_r <= bnd_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res_nxt;
    if (step && push && !beat.last_byte) end_stk_r[SIW'(sp_r)] <= push_val;
  end

  assign res_valid = res_valid_r;
  assign res = res_r;

  assert property (@(posedge clk) disable iff (!rst_n) sp_r <= SPW'(MAX_DEPTH))
    else $error("nesting depth beyond stack");
  assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) |-> (phase_r == PH_ERR))
    else $error("error without stop phase");
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && beat.last_byte) |=> res_valid)
    else $error("last byte gave no status");
endmodule

FILE: design/btw_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btw_out_queue
// Back end: queues result pairs and serializes them onto the output
// channel one record per beat.
// ----------------------------------------------------------------------------
module btw_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  btw_pkg::res_pair_t  wdata,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output btw_pkg::out_beat_t  out_data
);
  import btw_pkg::*;

  localparam int DEPTH = 4;

  res_pair_t   mem_r [DEPTH];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        half_r;
  logic        pop, take;

  // space counts the walker's in-flight pair too
  assign space     = cnt_r <= 3'(DEPTH - 2);
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = half_r ? mem_r[rp_r].r1 : mem_r[rp_r].r0;
  assign take      = out_valid && out_ready;
  assign pop       = take && (half_r || !mem_r[rp_r].two);
  assign cnt_nxt   = cnt_r + 3'(wr) - 3'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; half_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) wp_r <= wp_r + 2'd1;
      if (pop) begin
        rp_r <= rp_r + 2'd1; half_r <= 1'b0;
      end else if (take) begin
        half_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !(wr && cnt_r == 3'(DEPTH)))
    else $error("write into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) half_r |-> out_valid)
    else $error("second half without entry");
endmodule

FILE: design/ber_tlv_stream_walker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_tlv_stream_walker_core
// BER/DER TLV stream walker with object and status records.
// ----------------------------------------------------------------------------
// One byte is taken per cycle; the nesting stack is compared against the
// current offset in parallel so each byte is fully processed when taken.
// The first record of a byte passes the walker's result register and then
// the queue. A byte causes at most two records, which a small queue emits
// one per cycle while the output is ready. The input stalls whenever the
// queue holds more than two pairs, either behind a stalled output or
// when bytes yielding records arrive faster than one record per cycle.
module ber_tlv_stream_walker_core #(
  parameter int MAX_DEPTH   = btw_pkg::MAX_DEPTH_DEF,
  parameter int LEN_BYTES   = btw_pkg::LEN_BYTES_DEF,
  parameter int OFFSET_BITS = btw_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  btw_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output btw_pkg::out_beat_t  out_data
);
  import btw_pkg::*;

  logic      allow_r;
  logic      res_valid, space, step;
  res_pair_t res;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) allow_r <= 1'b1;
    else if (cfg_valid) allow_r <= cfg_data;
  end

  btw_walker #(
    .MAX_DEPTH(MAX_DEPTH), .LEN_BYTES(LEN_BYTES), .OFFSET_BITS(OFFSET_BITS)
  ) u_walker (
    .clk, .rst_n, .allow_indef(allow_r), .step, .beat(in_data),
    .res_valid, .res
  );

  btw_out_queue u_queue (
    .clk, .rst_n, .wr(res_valid), .wdata(res), .space,
    .out_valid, .out_ready, .out_data
  );
endmodule

FILE: tb/btw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btw_checker
// Watches the configuration, byte and record channels of the BER TLV walker.
// Every accepted byte is run through a cycle-free model of the walker: the
// nesting stack, the header decoding and the error rules. The records that
// the byte must cause are queued. Each accepted record is compared field by
// field with the oldest queued one. Failures and the queue depth are reported
// to the top level.
// ----------------------------------------------------------------------------
module btw_checker
  import btw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_beat_t out_data,
  output int        n_fail,
  output int        n_pend
);

  typedef enum logic [2:0] {
    PH_ID, PH_TAG, PH_LEN0, PH_LENN, PH_BODY, PH_ERR
  } walk_ph_t;

  localparam logic [63:0] OFF_LIM = 64'd1 << OFFSET_BITS_DEF;

  walk_ph_t    ph;
  logic        allow_indef;
  logic [27:0] tag_acc;
  logic [63:0] len_acc;
  int          len_left;
  int          hdr_cnt;
  logic [63:0] boff;
  logic [63:0] soff;
  logic [63:0] stk_end [0:MAX_DEPTH_DEF-1];
  logic        stk_ind [0:MAX_DEPTH_DEF-1];
  logic        stk_bnd [0:MAX_DEPTH_DEF-1];
  int          sp;
  logic [2:0]  err;
  logic [7:0]  idb;
  out_beat_t   step_q[$];
  out_beat_t   rec_q[$];

  task automatic clear_walk();
    ph = PH_ID;
    tag_acc = '0;
    len_acc = '0;
    len_left = 0;
    hdr_cnt = 0;
    boff = '0;
    soff = '0;
    for (int i = 0; i < MAX_DEPTH_DEF; i++) begin
      stk_end[i] = '0;
      stk_ind[i] = 1'b0;
      stk_bnd[i] = 1'b0;
    end
    sp = 0;
    err = ST_OK;
    idb = '0;
  endtask

  task automatic halt(logic [2:0] code);
    err = code;
    ph = PH_ERR;
  endtask

  task automatic put_rec(logic indef, logic [63:0] len, logic [2:0] st);
    out_beat_t r;
    r = '0;
    r.id_class = idb[7:6];
    r.constructed = idb[5];
    r.tag_number = tag_acc;
    r.level = sp[4:0];
    r.object_offset = soff[23:0];
    r.hdr_len = hdr_cnt[3:0];
    r.body_len = indef ? 32'd0 : len[31:0];
    r.indefinite = indef;
    r.status = st;
    step_q.push_back(r);
  endtask

  task automatic close_hdr(logic [63:0] pos, logic indef, logic [63:0] len);
    logic [63:0] lim;
    logic [63:0] oend;
    logic        bnd;
    logic        cons;
    logic        eoc;
    logic [2:0]  st;
    lim = OFF_LIM;
    bnd = 1'b0;
    cons = idb[5];
    eoc = 1'b0;
    st = ST_OK;
    oend = indef ? pos + 1 : pos + 1 + len;
    if (sp > 0) begin
      lim = stk_end[sp-1];
      bnd = stk_bnd[sp-1];
      eoc = !indef && len == 0 && idb == 8'h00 && stk_ind[sp-1];
    end
    if (indef && (!allow_indef || !cons)) st = ST_UNSUP;
    else if (oend > lim) st = bnd ? ST_OVERRUN : ST_UNSUP;
    else if (cons && sp >= MAX_DEPTH_DEF) st = ST_DEEP;
    put_rec(indef, len, st);
    if (st != ST_OK) begin
      halt(st);
      return;
    end
    ph = PH_ID;
    if (eoc) begin
      sp--;
    end else if (cons) begin
      stk_end[sp] = indef ? lim : oend;
      stk_ind[sp] = indef;
      stk_bnd[sp] = indef ? bnd : 1'b1;
      sp++;
    end else if (len > 0) begin
      len_acc = len;
      ph = PH_BODY;
    end
  endtask

  task automatic take_byte(logic [7:0] b);
    logic [63:0] pos;
    pos = boff;
    if (pos >= OFF_LIM) begin
      halt(ST_UNSUP);
      return;
    end
    boff = pos + 1;
    case (ph)
      PH_ID: begin
        soff = pos;
        idb = b;
        hdr_cnt = 1;
        if ((b & ID_TAG_M) == ID_TAG_M) begin
          tag_acc = '0;
          ph = PH_TAG;
        end else begin
          tag_acc = {23'd0, b[4:0]};
          ph = PH_LEN0;
        end
      end
      PH_TAG: begin
        if (hdr_cnt >= 5) begin
          halt(ST_UNSUP);
          return;
        end
        hdr_cnt++;
        tag_acc = {tag_acc[20:0], b[6:0]};
        if ((b & LEN_LONG_M) == 0) ph = PH_LEN0;
      end
      PH_LEN0: begin
        hdr_cnt++;
        if (b < LEN_LONG_M) begin
          close_hdr(pos, 1'b0, {56'd0, b});
        end else if (b == LEN_LONG_M) begin
          close_hdr(pos, 1'b1, 64'd0);
        end else if (b == 8'hff || (b & LOW7_M) > LEN_BYTES_DEF) begin
          halt(ST_UNSUP);
          return;
        end else begin
          len_acc = '0;
          len_left = b & LOW7_M;
          ph = PH_LENN;
        end
      end
      PH_LENN: begin
        hdr_cnt++;
        if ((len_acc >> 24) != 0) begin
          halt(ST_UNSUP);
          return;
        end
        len_acc = {len_acc[55:0], b};
        if (len_left > 0) len_left--;
        if (len_left == 0) close_hdr(pos, 1'b0, len_acc);
      end
      PH_BODY: begin
        if (len_acc > 0) len_acc--;
        if (len_acc == 0) ph = PH_ID;
      end
      default: return;
    endcase
    if (ph == PH_ID && err == ST_OK) begin
      while (sp > 0 && !stk_ind[sp-1] && stk_end[sp-1] == pos + 1) sp--;
    end
  endtask

  task automatic walk_beat(in_beat_t beat);
    out_beat_t r;
    step_q.delete();
    if (err == ST_OK) take_byte(beat.data_byte);
    if (beat.last_byte) begin
      if (err == ST_OK && (ph != PH_ID || sp > 0)) err = ST_TRUNC;
      r = '0;
      r.kind = 1'b1;
      r.level = sp[4:0];
      r.object_offset = boff[23:0];
      r.status = err;
      step_q.push_back(r);
      clear_walk();
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last_result = 1'b1;
    foreach (step_q[i]) rec_q.push_back(step_q[i]);
  endtask

  task automatic cmp_field(string nm, logic [31:0] e, logic [31:0] a, inout logic bad);
    if (e !== a) begin
      $display("%0t: %s expected %0h actual %0h", $time, nm, e, a);
      bad = 1'b1;
    end
  endtask

  task automatic check_rec(out_beat_t a);
    out_beat_t e;
    logic      bad;
    bad = 1'b0;
    if (rec_q.size() == 0) begin
      $display("%0t: record with nothing expected, actual %p", $time, a);
      n_fail++;
      return;
    end
    e = rec_q.pop_front();
    cmp_field("kind", e.kind, a.kind, bad);
    cmp_field("id_class", e.id_class, a.id_class, bad);
    cmp_field("constructed", e.constructed, a.constructed, bad);
    cmp_field("tag_number", e.tag_number, a.tag_number, bad);
    cmp_field("level", e.level, a.level, bad);
    cmp_field("object_offset", e.object_offset, a.object_offset, bad);
    cmp_field("hdr_len", e.hdr_len, a.hdr_len, bad);
    cmp_field("body_len", e.body_len, a.body_len, bad);
    cmp_field("indefinite", e.indefinite, a.indefinite, bad);
    cmp_field("status", e.status, a.status, bad);
    cmp_field("last_result", e.last_result, a.last_result, bad);
    if (bad) n_fail++;
  endtask

  initial begin
    n_fail = 0;
    n_pend = 0;
    allow_indef = 1'b1;
    clear_walk();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_walk();
      allow_indef = 1'b1;
      rec_q.delete();
    end else begin
      if (out_valid && out_ready) check_rec(out_data);
      if (cfg_valid && cfg_ready) allow_indef = cfg_data;
      if (in_valid && in_ready) walk_beat(in_data);
    end
    n_pend = rec_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the BER TLV walker. Directed streams cover the header limits,
// the error rules and deep nesting. Random phases then send well-formed TLV
// trees with random content, with truncated streams and raw noise mixed in.
// Idle patterns change per phase, and the checker gives the verdict data.
// ----------------------------------------------------------------------------
module tb_top;
  import btw_pkg::*;

  typedef logic [7:0] bq_t[$];

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  int        n_fail;
  int        n_pend;
  int        snd_idle = 0;
  int        rcv_idle = 0;
  logic      hold_req = 1'b0;
  int        sent = 0;
  int        quiet = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ber_tlv_stream_walker_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  btw_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .n_fail(n_fail), .n_pend(n_pend)
  );

  // hold off the record channel for a long stretch on request
  always @(posedge clk) begin
    if (hold_req) begin
      out_ready <= 1'b0;
      repeat (300) @(posedge clk);
      hold_req = 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= 3000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic send_stream(bq_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pend != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic bq_t make_obj(int depth);
    bq_t       res;
    bq_t       body;
    logic      cons;
    logic      indef;
    logic [1:0] cls;
    int        nb;
    int        len;
    int        k;
    cons = (depth < 5) && ($urandom_range(0, 1) == 1);
    cls = $urandom_range(0, 3);
    if ($urandom_range(0, 3) != 0) begin
      res.push_back({cls, cons, 5'($urandom_range(0, 30))});
    end else begin
      res.push_back({cls, cons, 5'h1f});
      nb = ($urandom_range(0, 40) == 0) ? 5 : $urandom_range(1, 4);
      for (int i = 0; i < nb; i++)
        res.push_back({i != nb - 1, 7'($urandom())});
    end
    if (cons) begin
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++) body = {body, make_obj(depth + 1)};
    end else begin
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 6);
      for (int i = 0; i < len; i++) body.push_back(8'($urandom()));
    end
    indef = cons && ($urandom_range(0, 3) == 0);
    if (indef) begin
      res.push_back(8'h80);
      res = {res, body};
      res.push_back(8'h00);
      res.push_back(8'h00);
      return res;
    end
    len = body.size();
    if ($urandom_range(0, 39) == 0) len = len + $urandom_range(0, 2);
    else if ($urandom_range(0, 39) == 0 && len > 0) len = len - 1;
    if (len < 128 && $urandom_range(0, 2) != 0) begin
      res.push_back(8'(len));
    end else begin
      nb = (len > 255) ? 2 : 1;
      nb = $urandom_range(nb, 4);
      res.push_back(8'h80 | 8'(nb));
      for (int i = nb - 1; i >= 0; i--) res.push_back(8'(len >> (8 * i)));
    end
    return {res, body};
  endfunction

  task automatic random_phase(int target);
    bq_t s;
    int  r;
    int  stop;
    stop = sent + target;
    while (sent < stop) begin
      s.delete();
      r = $urandom_range(0, 19);
      if (r < 2) begin
        for (int i = $urandom_range(1, 6); i > 0; i--) s.push_back(8'($urandom()));
      end else begin
        for (int i = $urandom_range(1, 3); i > 0; i--) s = {s, make_obj(0)};
        if (r == 2 && s.size() > 1) s = s[0:$urandom_range(0, s.size() - 2)];
      end
      send_stream(s);
    end
  endtask

  initial begin
    bq_t deep;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_cfg(1'b1);
    send_stream('{8'h30, 8'h80, 8'h02, 8'h01, 8'h05, 8'h00, 8'h00});
    send_stream('{8'h1f, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h00});
    send_stream('{8'hdf, 8'h81, 8'h82, 8'h83, 8'h84, 8'h05});
    send_stream('{8'h04, 8'hff});
    send_stream('{8'h04, 8'h85});
    send_stream('{8'h44, 8'h84, 8'hff, 8'hff, 8'hff, 8'hff});
    send_stream('{8'h30, 8'h03, 8'h04, 8'h05, 8'h00});
    send_stream('{8'h04, 8'h80});
    send_stream('{8'h00, 8'h00});
    send_stream('{8'h30, 8'h02, 8'h04});
    send_stream('{8'h84, 8'h82, 8'h00, 8'h02, 8'haa, 8'hbb, 8'he0, 8'h00});
    for (int i = 0; i < 17; i++) begin
      deep.push_back(8'ha0);
      deep.push_back(8'h80);
    end
    send_stream(deep);
    write_cfg(1'b0);
    send_stream('{8'h30, 8'h80, 8'h00, 8'h00});
    snd_idle = 16;
    rcv_idle = 70;
    random_phase(330);
    write_cfg(1'b1);
    snd_idle = 70;
    rcv_idle = 16;
    random_phase(330);
    // let every record drain before the next phase starts
    drain();
    snd_idle = 0;
    rcv_idle = 0;
    hold_req = 1'b1;
    random_phase(330);
    write_cfg(1'b0);
    random_phase(40);
    drain();
    repeat (20) @(posedge clk);
    if (n_fail == 0 && n_pend == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
